// ===== sv/dse_pkg.sv =====
// Shared types, constants and helper functions for the date string converter.
// No dependencies; every other file of the block but dse_ram imports this package.
package dse_pkg;

    localparam int DSE_MAX_CHARS = 16;

    localparam int CHAR_W   = 8;
    localparam int SECS_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Accumulator: days since the epoch up to 2155 times 86400 needs 33 bits,
    // one more keeps the overflow test simple.
    localparam int ACC_W = 34;
    localparam int MUL_W = 6;
    localparam int ADD_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_YEAR  = 2'd2;

    localparam logic [4:0] RST_DEFAULT_DAY   = 5'd1;
    localparam logic [3:0] RST_DEFAULT_MONTH = 4'd1;
    localparam logic [7:0] RST_DEFAULT_YEAR  = 8'd70;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic [7:0] EPOCH_YY     = 8'd70;   // 1970 as years since 1900
    localparam logic [6:0] MAX_MONTH    = 7'd12;
    localparam logic [6:0] MAX_DAY      = 7'd31;
    localparam logic [6:0] MAX_MIN_SEC  = 7'd59;
    localparam logic [6:0] HOUR_ROLL    = 7'd24;
    localparam logic [3:0] LEAP_MONTH   = 4'd3;

    localparam logic [MUL_W-1:0] MUL_ONE       = 6'd1;
    localparam logic [MUL_W-1:0] HOURS_PER_DAY = 6'd24;
    localparam logic [MUL_W-1:0] SIXTY         = 6'd60;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_DIGIT,
        S_CHECK,
        S_YEARS,
        S_MONTHS,
        S_DAYS,
        S_HOURS,
        S_MINS,
        S_SECS,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        F_FIRST,
        F_DOT,
        F_MIN,
        F_HOUR,
        F_DAY,
        F_MON,
        F_YEAR,
        F_END
    } t_field;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Years since 1900 in 70..255: divisible by four is leap, except 2100.
    function automatic logic is_leap(input logic [7:0] yy);
        return (yy[1:0] == 2'b00) && (yy != 8'd200);
    endfunction

    function automatic logic [ADD_W-1:0] year_days(input logic [7:0] yy);
        return is_leap(yy) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/dse_if.sv =====
// Handshake interfaces for the character, result and configuration channels.
// Depends on dse_pkg for the payload widths.
interface dse_char_if import dse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface dse_result_if import dse_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              bad_format;
    logic [SECS_W-1:0] epoch_seconds;

    modport source (output valid, bad_format, epoch_seconds, input ready);
    modport sink   (input valid, bad_format, epoch_seconds, output ready);
endinterface

interface dse_cfg_if import dse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dse_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dse_mac.sv =====
// Shared multiply-add unit: sum = acc * mul + add, truncated to the accumulator.
// Depends on dse_pkg for the widths.
module dse_mac import dse_pkg::*; (
    input  logic [ACC_W-1:0] i_acc,
    input  logic [MUL_W-1:0] i_mul,
    input  logic [ADD_W-1:0] i_add,
    output logic [ACC_W-1:0] o_sum
);

    logic [ACC_W+MUL_W-1:0] prod;

    assign prod  = i_acc * i_mul;
    assign o_sum = prod[ACC_W-1:0] + ACC_W'(i_add);

endmodule

// ===== sv/date_string_to_epoch_seconds.sv =====
// Date string to seconds since 1970: top level with the parse and convert sequencer.
// Depends on dse_pkg, the interfaces in dse_if, dse_ram and dse_mac.

// The block takes a date string of the form [YY[MM[DD]]]HHMM[.SS] one character
// per request on i_char, one request per cycle while i_char.ready is high, and
// answers every request marked last_char with one result request on o_result:
// bad_format, or the seconds since 1970-01-01 00:00:00 (zero when bad_format is
// set). Missing day, month and year come from the three configuration
// registers on i_cfg (0: default day, 1: default month, 2: default year as
// years since 1900), which accept a write in every cycle and should be written
// only while no string is in progress. Strings longer than MAX_CHARS
// characters are rejected. After the last character the block is busy while
// the parser reads the character buffer from its right end through a single
// registered read port, and the conversion then runs the year sum, the month
// sum and the scaling to seconds one step a cycle through a single shared
// multiply-add unit. The result waits in an output register, so a new string
// can be loaded while the previous result is still to be taken.
module date_string_to_epoch_seconds import dse_pkg::*; #(
    parameter int MAX_CHARS = DSE_MAX_CHARS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dse_char_if.sink     i_char,
    dse_cfg_if.sink      i_cfg,
    dse_result_if.source o_result
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int AW = $clog2(MAX_CHARS);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CHARS);

    // Control state.
    t_state r_state, n_state;
    t_field r_field, n_field;
    logic            r_tens, n_tens;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_pos, n_pos;
    logic            r_bad, n_bad;
    logic            r_miss, n_miss;
    logic            r_out_valid, n_out_valid;

    // Configuration.
    logic [4:0] r_def_day, n_def_day;
    logic [3:0] r_def_mon, n_def_mon;
    logic [7:0] r_def_year, n_def_year;

    // Parsed fields and the conversion datapath.
    logic [6:0]       r_val, n_val;
    logic [6:0]       r_secs, n_secs;
    logic [6:0]       r_mins, n_mins;
    logic [6:0]       r_hour, n_hour;
    logic [6:0]       r_day, n_day;
    logic [6:0]       r_mon, n_mon;
    logic [7:0]       r_year, n_year;
    logic [7:0]       r_y, n_y;
    logic [3:0]       r_m, n_m;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_out_bad, n_out_bad;
    logic [SECS_W-1:0] r_out_secs, n_out_secs;

    logic             char_acc;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;
    logic [CW-1:0]    pos_m1;

    logic             commit;
    logic [7:0]       fval;
    logic             dig;
    logic [3:0]       dval;
    logic [7:0]       tens10;
    logic             range_err;
    logic             leap_adj;
    logic             fin_bad;
    logic             slot_free;

    logic [MUL_W-1:0] mac_mul;
    logic [ADD_W-1:0] mac_add;
    logic [ACC_W-1:0] mac_sum;

    // Handshakes.
    assign i_char.ready      = (r_state == S_IDLE);
    assign char_acc          = i_char.valid && i_char.ready;
    assign i_cfg.ready       = 1'b1;
    assign o_result.valid    = r_out_valid;
    assign o_result.bad_format    = r_out_bad;
    assign o_result.epoch_seconds = r_out_secs;

    // The character buffer. Characters beyond MAX_CHARS are not written; the
    // parser always reads the entry just left of the current position.
    assign ram_we    = char_acc && (r_count < MAX_COUNT);
    assign pos_m1    = r_pos - CW'(1);
    assign ram_raddr = pos_m1[AW-1:0];

    dse_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_CHARS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_char.char_code),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dse_mac u_mac (
        .i_acc (r_acc),
        .i_mul (mac_mul),
        .i_add (mac_add),
        .o_sum (mac_sum)
    );

    // Character decode for the entry just read.
    assign dig    = is_digit(ram_rdata);
    assign dval   = 4'(ram_rdata - CH_ZERO);
    assign tens10 = 8'({dval, 3'b000}) + 8'({dval, 1'b0});

    assign range_err = r_bad || r_miss || (r_pos != '0)
                    || (r_mon == 7'd0) || (r_mon > MAX_MONTH)
                    || (r_day == 7'd0) || (r_day > MAX_DAY)
                    || (r_mins > MAX_MIN_SEC) || (r_secs > MAX_MIN_SEC)
                    || (r_hour > HOUR_ROLL) || (r_year < EPOCH_YY);

    // February 29th is counted once the month is March or later.
    assign leap_adj  = is_leap(r_year) && (r_mon[3:0] >= LEAP_MONTH);
    assign fin_bad   = r_bad || (r_acc[ACC_W-1:SECS_W] != '0);
    assign slot_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_def_day   <= RST_DEFAULT_DAY;
            r_def_mon   <= RST_DEFAULT_MONTH;
            r_def_year  <= RST_DEFAULT_YEAR;
        end else begin
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_def_day   <= n_def_day;
            r_def_mon   <= n_def_mon;
            r_def_year  <= n_def_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_field    <= n_field;
        r_tens     <= n_tens;
        r_pos      <= n_pos;
        r_bad      <= n_bad;
        r_miss     <= n_miss;
        r_val      <= n_val;
        r_secs     <= n_secs;
        r_mins     <= n_mins;
        r_hour     <= n_hour;
        r_day      <= n_day;
        r_mon      <= n_mon;
        r_year     <= n_year;
        r_y        <= n_y;
        r_m        <= n_m;
        r_acc      <= n_acc;
        r_out_bad  <= n_out_bad;
        r_out_secs <= n_out_secs;
    end

    always_comb begin
        n_state     = r_state;
        n_field     = r_field;
        n_tens      = r_tens;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_bad       = r_bad;
        n_miss      = r_miss;
        n_val       = r_val;
        n_secs      = r_secs;
        n_mins      = r_mins;
        n_hour      = r_hour;
        n_day       = r_day;
        n_mon       = r_mon;
        n_year      = r_year;
        n_y         = r_y;
        n_m         = r_m;
        n_acc       = r_acc;
        n_out_bad   = r_out_bad;
        n_out_secs  = r_out_secs;
        n_out_valid = r_out_valid && !o_result.ready;
        n_def_day   = r_def_day;
        n_def_mon   = r_def_mon;
        n_def_year  = r_def_year;
        commit      = 1'b0;
        fval        = 8'd0;
        mac_mul     = MUL_ONE;
        mac_add     = '0;

        // Configuration writes; an index beyond the list is ignored.
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEFAULT_DAY:   n_def_day  = i_cfg.data[4:0];
                CFG_DEFAULT_MONTH: n_def_mon  = i_cfg.data[3:0];
                CFG_DEFAULT_YEAR:  n_def_year = i_cfg.data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (char_acc) begin
                    if (r_count < MAX_COUNT) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    // On the last character the parse starts from the right
                    // end and the buffer is free again for the next string.
                    if (i_char.last_char) begin
                        n_pos   = (r_count < MAX_COUNT) ? r_count + CW'(1) : r_count;
                        n_bad   = r_ovf || (r_count == MAX_COUNT);
                        n_miss  = 1'b0;
                        n_field = F_FIRST;
                        n_tens  = 1'b0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_FETCH;
                    end
                end
            end

            // Field dispatch: the read address is presented in this cycle.
            S_FETCH: begin
                if (r_tens) begin
                    n_state = S_DIGIT;
                end else begin
                    case (r_field)
                        F_END: n_state = S_CHECK;
                        F_DOT: begin
                            if (r_pos == '0) begin
                                // No seconds part: the first pair was minutes.
                                n_mins  = r_secs;
                                n_secs  = 7'd0;
                                n_field = F_HOUR;
                            end else begin
                                n_state = S_DIGIT;
                            end
                        end
                        default: begin
                            if (r_pos == '0) begin
                                // String used up: date fields take their
                                // defaults, time fields are an error.
                                commit = 1'b1;
                                case (r_field)
                                    F_DAY:  fval = {3'b000, r_def_day};
                                    F_MON:  fval = {4'b0000, r_def_mon};
                                    F_YEAR: fval = r_def_year;
                                    default: begin
                                        fval   = 8'd0;
                                        n_miss = 1'b1;
                                    end
                                endcase
                            end else begin
                                n_state = S_DIGIT;
                            end
                        end
                    endcase
                end
            end

            // Buffer data is valid here.
            S_DIGIT: begin
                n_state = S_FETCH;
                if (r_field == F_DOT) begin
                    if (ram_rdata == CH_DOT) begin
                        n_pos   = pos_m1;
                        n_field = F_MIN;
                    end else begin
                        n_mins  = r_secs;
                        n_secs  = 7'd0;
                        n_field = F_HOUR;
                    end
                end else if (!r_tens) begin
                    n_pos = pos_m1;
                    if (!dig) begin
                        n_bad = 1'b1;
                    end
                    n_val = {3'b000, dval};
                    if (r_pos > CW'(1)) begin
                        n_tens = 1'b1;
                    end else begin
                        // A lone leading digit is the units digit.
                        commit = 1'b1;
                        fval   = {4'b0000, dval};
                    end
                end else begin
                    n_pos = pos_m1;
                    if (!dig) begin
                        n_bad = 1'b1;
                    end
                    commit = 1'b1;
                    fval   = {1'b0, r_val} + tens10;
                end
            end

            S_CHECK: begin
                if (range_err) begin
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // Hour 24 is midnight at the start of the next day.
                    if (r_hour == HOUR_ROLL) begin
                        n_hour = 7'd0;
                        n_day  = r_day + 7'd1;
                    end
                    n_acc   = '0;
                    n_y     = EPOCH_YY;
                    n_state = S_YEARS;
                end
            end

            S_YEARS: begin
                mac_add = year_days(r_y);
                if (r_y < r_year) begin
                    n_acc = mac_sum;
                    n_y   = r_y + 8'd1;
                end else begin
                    n_m     = 4'd1;
                    n_state = S_MONTHS;
                end
            end

            S_MONTHS: begin
                mac_add = ADD_W'(month_days(r_m));
                if ({3'b000, r_m} < r_mon) begin
                    n_acc = mac_sum;
                    n_m   = r_m + 4'd1;
                end else begin
                    n_state = S_DAYS;
                end
            end

            S_DAYS: begin
                mac_add = ADD_W'(r_day) - ADD_W'(1) + ADD_W'(leap_adj);
                n_acc   = mac_sum;
                n_state = S_HOURS;
            end

            S_HOURS: begin
                mac_mul = HOURS_PER_DAY;
                mac_add = ADD_W'(r_hour);
                n_acc   = mac_sum;
                n_state = S_MINS;
            end

            S_MINS: begin
                mac_mul = SIXTY;
                mac_add = ADD_W'(r_mins);
                n_acc   = mac_sum;
                n_state = S_SECS;
            end

            S_SECS: begin
                mac_mul = SIXTY;
                mac_add = ADD_W'(r_secs);
                n_acc   = mac_sum;
                n_state = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_bad   = fin_bad;
                    n_out_secs  = fin_bad ? '0 : r_acc[SECS_W-1:0];
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // A finished pair goes to its field and the parser moves left.
        if (commit) begin
            n_tens  = 1'b0;
            n_state = S_FETCH;
            case (r_field)
                F_FIRST: begin
                    n_secs  = fval[6:0];
                    n_field = F_DOT;
                end
                F_MIN: begin
                    n_mins  = fval[6:0];
                    n_field = F_HOUR;
                end
                F_HOUR: begin
                    n_hour  = fval[6:0];
                    n_field = F_DAY;
                end
                F_DAY: begin
                    n_day   = fval[6:0];
                    n_field = F_MON;
                end
                F_MON: begin
                    n_mon   = fval[6:0];
                    n_field = F_YEAR;
                end
                F_YEAR: begin
                    n_year  = fval;
                    n_field = F_END;
                end
                default: n_field = F_END;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_COUNT)
        else $error("character count beyond buffer depth");

    a_last_starts_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        char_acc && i_char.last_char |=> (r_count == '0) && (r_state == S_FETCH))
        else $error("last character did not start the parse");

    a_bad_zero_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> (r_out_secs == '0))
        else $error("rejected string carries non-zero seconds");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_pos <= MAX_COUNT))
        else $error("parse position beyond buffer depth");

    a_tens_has_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) && r_tens |-> (r_pos != '0))
        else $error("tens digit read with no character left");
`endif

endmodule

// ===== tb/date_string_to_epoch_seconds_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for date_string_to_epoch_seconds: date strings go in one
// character per request, and each result is checked against a predictor in this file.
// Depends on dse_pkg, the interfaces in dse_if and the block itself.

module date_string_to_epoch_seconds_tb;
    import dse_pkg::*;

    // The end of the run waits longer than the slowest conversion takes, and the
    // watchdog is well beyond both that wait and the long hold-off on the result side.
    localparam int unsigned DRAIN_CYCLES    = 300;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned ITEMS_PER_PHASE = 300;

    // Fields of a date string, from its left end to its right end.
    typedef enum int unsigned {
        FLD_YEAR,
        FLD_MONTH,
        FLD_DAY,
        FLD_HOUR,
        FLD_MIN,
        FLD_SEC
    } date_field_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              is_last;
    } char_req_t;

    typedef struct packed {
        logic              bad;
        logic [SECS_W-1:0] secs;
    } epoch_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dse_char_if   char_bus ();
    dse_cfg_if    cfg_bus ();
    dse_result_if result_bus ();

    date_string_to_epoch_seconds uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .i_cfg   (cfg_bus),
        .o_result(result_bus)
    );

    // Character requests still to be offered, and the results still owed by the block.
    char_req_t     char_queue[$];
    epoch_result_t epoch_due[$];
    logic [7:0]    draft[$];

    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    bit          hold_request   = 1'b0;
    bit          char_sent      = 1'b0;

    // Predictor state: the characters held so far for the current string, and a
    // copy of the three default registers.
    logic [7:0]  held_chars [DSE_MAX_CHARS];
    int unsigned held_count    = 0;
    bit          held_overflow = 1'b0;
    logic [4:0]  dflt_day      = RST_DEFAULT_DAY;
    logic [3:0]  dflt_month    = RST_DEFAULT_MONTH;
    logic [7:0]  dflt_year     = RST_DEFAULT_YEAR;
    int unsigned month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int unsigned year_length(input int unsigned y);
        return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
    endfunction

    // Takes one digit pair off the right end of the held string. The rightmost
    // character is the units digit; a lone leftover character has tens zero.
    // An empty string yields the default and flags the field as missing.
    function automatic int unsigned read_digit_pair(inout int unsigned pos,
                                                    input int unsigned dflt,
                                                    inout bit missing,
                                                    inout bit bad);
        logic [7:0]  units;
        logic [7:0]  tens;
        int unsigned u_val;
        int unsigned t_val;
        if (pos == 0) begin
            missing = 1'b1;
            return dflt;
        end
        units = held_chars[pos-1];
        pos--;
        if (pos > 0) begin
            tens = held_chars[pos-1];
            pos--;
        end else begin
            tens = CH_ZERO;
        end
        if (units < CH_ZERO || units > CH_NINE || tens < CH_ZERO || tens > CH_NINE) begin
            bad = 1'b1;
            return 0;
        end
        u_val = units - CH_ZERO;
        t_val = tens - CH_ZERO;
        return u_val + 10 * t_val;
    endfunction

    // Parses the held string and converts it to seconds since 1970. Returns 0 when
    // the string is malformed, out of range or beyond 32 bits.
    function automatic bit civil_to_epoch(output logic [SECS_W-1:0] secs);
        int unsigned     pos;
        int unsigned     sec_f, min_f, hour_f, day_f, mon_f, year_f;
        int unsigned     y, m;
        bit              miss, dmiss, bad;
        longint unsigned days, total;
        secs  = '0;
        pos   = held_count;
        bad   = held_overflow;
        miss  = 1'b0;
        dmiss = 1'b0;
        sec_f = read_digit_pair(pos, 0, miss, bad);
        if (pos > 0 && held_chars[pos-1] == CH_DOT) begin
            pos--;
            min_f = read_digit_pair(pos, 0, miss, bad);
        end else begin
            min_f = sec_f;
            sec_f = 0;
        end
        hour_f = read_digit_pair(pos, 0, miss, bad);
        day_f  = read_digit_pair(pos, dflt_day, dmiss, bad);
        mon_f  = read_digit_pair(pos, dflt_month, dmiss, bad);
        year_f = read_digit_pair(pos, dflt_year, dmiss, bad);
        if (miss || bad || pos != 0)
            return 1'b0;
        if (mon_f < 1 || mon_f > 12 || day_f < 1 || day_f > 31 || min_f > 59 || sec_f > 59)
            return 1'b0;
        // Hour 24 is midnight at the start of the following day.
        if (hour_f == 24) begin
            hour_f = 0;
            day_f++;
        end
        if (hour_f > 23)
            return 1'b0;
        year_f += 1900;
        if (year_f < 1970)
            return 1'b0;
        days = 0;
        for (y = 1970; y < year_f; y++)
            days += year_length(y);
        if (year_length(year_f) == 366 && mon_f >= 3)
            days++;
        for (m = 1; m < mon_f; m++)
            days += month_len[m-1];
        days += day_f - 1;
        total = ((days * 24 + hour_f) * 60 + min_f) * 60 + sec_f;
        if (total > 64'hFFFF_FFFF)
            return 1'b0;
        secs = total[SECS_W-1:0];
        return 1'b1;
    endfunction

    // Called for every accepted character request. Characters beyond the buffer
    // size are dropped and spoil the string; the last one produces a result.
    function automatic void buffer_char(input logic [7:0] code, input logic is_last);
        epoch_result_t due;
        logic [SECS_W-1:0] secs;
        if (held_count < DSE_MAX_CHARS) begin
            held_chars[held_count] = code;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (is_last) begin
            due.bad  = !civil_to_epoch(secs);
            due.secs = due.bad ? '0 : secs;
            epoch_due.push_back(due);
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Character driver: offers the head of char_queue, holding it until taken.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            buffer_char(char_bus.char_code, char_bus.last_char);
            void'(char_queue.pop_front());
            char_sent = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            char_bus.valid <= 1'b0;
        end else if (!char_bus.valid || char_sent) begin
            char_sent = 1'b0;
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                char_bus.valid     <= 1'b1;
                char_bus.char_code <= char_queue[0].code;
                char_bus.last_char <= char_queue[0].is_last;
            end else begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request, counted here.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each result request is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin
        epoch_result_t due;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (epoch_due.size() == 0) begin
                $display("%0t: result with none outstanding: bad_format %0b epoch_seconds %0d",
                         $time, result_bus.bad_format, result_bus.epoch_seconds);
                error_count++;
            end else begin
                due = epoch_due.pop_front();
                if (result_bus.bad_format !== due.bad) begin
                    $display("%0t: bad_format expected %0b, got %0b",
                             $time, due.bad, result_bus.bad_format);
                    error_count++;
                end
                if (result_bus.epoch_seconds !== due.secs) begin
                    $display("%0t: epoch_seconds expected %0d, got %0d",
                             $time, due.secs, result_bus.epoch_seconds);
                    error_count++;
                end
            end
        end
    end

    // Cycles in which no request of any kind was accepted, for the watchdog.
    always @(posedge i_clk) begin
        if ((char_bus.valid && char_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
            (result_bus.valid && result_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        // The write has been taken at this edge, so the predictor follows it here.
        case (idx)
            CFG_DEFAULT_DAY:   dflt_day   = value[4:0];
            CFG_DEFAULT_MONTH: dflt_month = value[3:0];
            CFG_DEFAULT_YEAR:  dflt_year  = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_draft();
        char_req_t req;
        foreach (draft[i]) begin
            req.code    = draft[i];
            req.is_last = (i == draft.size() - 1);
            char_queue.push_back(req);
        end
    endtask

    task automatic queue_text(input string text);
        draft.delete();
        for (int i = 0; i < text.len(); i++)
            draft.push_back(text[i]);
        queue_draft();
    endtask

    task automatic draft_pair(input int unsigned v, input bit units_only);
        if (!units_only)
            draft.push_back(CH_ZERO + 8'(v / 10));
        draft.push_back(CH_ZERO + 8'(v % 10));
    endtask

    // Mostly an in-range value; now and then anything two digits can hold.
    function automatic int unsigned pick_field(input date_field_t f);
        if ($urandom_range(9) == 0)
            return $urandom_range(99);
        case (f)
            FLD_YEAR:  return $urandom_range(99, 70);
            FLD_MONTH: return $urandom_range(12, 1);
            FLD_DAY:   return $urandom_range(31, 1);
            FLD_HOUR:  return $urandom_range(24);
            default:   return $urandom_range(59);
        endcase
    endfunction

    function automatic logic [7:0] random_char();
        case ($urandom_range(9))
            0:       return CH_DOT;
            1, 2, 3: return 8'($urandom_range(255));
            default: return CH_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    // A well-formed string: HHMM with up to three leading fields, sometimes with
    // only the units digit of the leading field, and sometimes with seconds.
    task automatic draft_well_formed();
        int unsigned first;
        bit          odd_lead;
        first    = $urandom_range(FLD_HOUR);
        odd_lead = ($urandom_range(9) == 0);
        draft.delete();
        for (int unsigned f = first; f <= FLD_MIN; f++)
            draft_pair(pick_field(date_field_t'(f)), odd_lead && f == first);
        if ($urandom_range(9) < 4) begin
            draft.push_back(CH_DOT);
            draft_pair(pick_field(FLD_SEC), 1'b0);
        end
    endtask

    // Most strings are well formed; the rest are damaged, pure noise, or carry
    // extra leading digits that are either left over after the year or push the
    // string past the buffer size.
    task automatic draft_date();
        int unsigned kind;
        int unsigned pos;
        int unsigned n;
        kind = $urandom_range(99);
        draft_well_formed();
        if (kind >= 65 && kind < 80) begin
            pos = $urandom_range(draft.size() - 1);
            case ($urandom_range(2))
                0: draft[pos] = random_char();
                1: draft.insert(pos, random_char());
                default: begin
                    if (draft.size() > 1)
                        draft.delete(pos);
                end
            endcase
        end else if (kind >= 80 && kind < 92) begin
            draft.delete();
            n = $urandom_range(20, 1);
            repeat (n) draft.push_back(random_char());
        end else if (kind >= 92) begin
            n = $urandom_range(12, 1);
            repeat (n) draft.push_front(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    task automatic wait_drained();
        while (char_queue.size() != 0 || epoch_due.size() != 0)
            @(posedge i_clk);
    endtask

    // One phase: set the defaults while the block is idle, pick the idling mix,
    // then send random strings until the item budget is spent.
    task automatic run_phase(input logic [4:0] day, input logic [3:0] month,
                             input logic [7:0] year, input int unsigned send_pct,
                             input int unsigned recv_pct, input bit hold_off);
        int unsigned items;
        write_reg(CFG_DEFAULT_DAY, {3'b000, day});
        write_reg(CFG_DEFAULT_MONTH, {4'b0000, month});
        write_reg(CFG_DEFAULT_YEAR, year);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        @(posedge i_clk);
        if (hold_off)
            hold_request = 1'b1;
        items = 0;
        while (items < ITEMS_PER_PHASE) begin
            draft_date();
            queue_draft();
            items += draft.size();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        char_bus.valid      = 1'b0;
        char_bus.char_code  = '0;
        char_bus.last_char  = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_DEFAULT_DAY;
        cfg_bus.data        = '0;
        result_bus.ready    = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset defaults: the epoch itself, an all-ones
        // byte and a zero byte as lone characters, a single leading units digit,
        // hour 24 on the last day of 1999 rolling into 2000, and an hour too large.
        queue_text("0000");
        draft.delete();
        draft.push_back(8'hFF);
        queue_draft();
        draft.delete();
        draft.push_back(8'h00);
        queue_draft();
        queue_text("123");
        queue_text("9912312459");
        queue_text("2500");
        wait_drained();

        // Lowest defaults with no idling, highest with a sparse sender, then random
        // defaults under stalls, a leap-day default under a long result hold-off,
        // and finally a default year late enough for the seconds to overflow.
        run_phase(5'd1, 4'd1, 8'd70, 0, 0, 1'b0);
        run_phase(5'd31, 4'd12, 8'd199, 69, 0, 1'b0);
        run_phase(5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)),
                  8'($urandom_range(199, 70)), 0, 69, 1'b0);
        run_phase(5'($urandom_range(31, 1)), 4'($urandom_range(12, 1)),
                  8'($urandom_range(199, 70)), 27, 27, 1'b0);
        run_phase(5'd29, 4'd2, 8'd100, 0, 0, 1'b1);
        run_phase(5'd31, 4'd12, 8'd255, 27, 27, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
